@@ hw/rtl/fisp_pkg.sv @@
package fisp_pkg;

    localparam int OP_W     = 2;
    localparam int INDEX_W  = 16;
    localparam int OFFSET_W = 26;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 11;
    localparam int OBJ_W    = 16;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    localparam logic [INDEX_W-1:0] NONE_INDEX        = '1;
    localparam logic [SIZE_W-1:0]  POOL_SIZE_RESET   = 11'd1024;
    localparam logic [OBJ_W-1:0]   OBJECT_SIZE_RESET = 16'd64;

    typedef enum logic [OP_W-1:0] {
        OP_OBTAIN   = 2'd0,
        OP_RELEASE  = 2'd1,
        OP_FREE_ALL = 2'd2,
        OP_ACCESS   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_INVALID   = 2'd3
    } status_t;

    // register index, selected by paddr[2]
    typedef enum logic {
        REG_POOL_SIZE   = 1'b0,
        REG_OBJECT_SIZE = 1'b1
    } reg_sel_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_flags_t;

endpackage

@@ hw/rtl/fisp_if.sv @@
interface fisp_req_if
    import fisp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] index;

    modport source (output valid, output op, output index, input ready);
    modport sink   (input valid, input op, input index, output ready);
endinterface

interface fisp_rsp_if
    import fisp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [INDEX_W-1:0]  slot;
    logic [OFFSET_W-1:0] byte_offset;
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   used_count;

    modport source (output valid, output slot, output byte_offset, output status,
                    output used_count, input ready);
    modport sink   (input valid, input slot, input byte_offset, input status,
                    input used_count, output ready);
endinterface

@@ hw/rtl/fisp_ram.sv @@
module fisp_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/fisp_ctrl.sv @@
module fisp_ctrl
    import fisp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_flags_t  flags,
    output ctrl_cmd_t  cmd
);
    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!flags.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            S_EXEC:
            begin
                cmd.commit = !flags.out_busy;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end
endmodule

@@ hw/rtl/fisp_dp.sv @@
module fisp_dp
    import fisp_pkg::*;
#(
    parameter int POOL_DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output dp_flags_t           flags,
    input  logic [OP_W-1:0]     op,
    input  logic [INDEX_W-1:0]  index,
    input  logic [SIZE_W-1:0]   pool_size,
    input  logic [OBJ_W-1:0]    object_size,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [INDEX_W-1:0]  slot,
    output logic [OFFSET_W-1:0] byte_offset,
    output logic [STATUS_W-1:0] status,
    output logic [SIZE_W-1:0]   used_count
);
    localparam int IDX_W = $clog2(POOL_DEPTH);
    localparam logic [SIZE_W-1:0] ACTIVE_RESET =
        (POOL_DEPTH < 1024) ? SIZE_W'(POOL_DEPTH) : POOL_SIZE_RESET;

    logic [OP_W-1:0]     op_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [SIZE_W-1:0]   head_reg,   head_next;
    logic [SIZE_W-1:0]   mark_reg,   mark_next;
    logic [SIZE_W-1:0]   active_reg, active_next;
    logic                out_valid_reg;
    logic [INDEX_W-1:0]  slot_reg,   slot_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    status_t             status_reg, status_next;
    logic [SIZE_W-1:0]   used_reg;

    logic                we;
    logic [IDX_W-1:0]    rdata;
    logic [SIZE_W-1:0]   clamped;
    logic [INDEX_W-1:0]  mul_a;
    logic                mul_en;
    logic [2*INDEX_W-1:0] product;

    // Stack entries at or above the fill mark were never pushed since the
    // last refill and still hold their own position.
    fisp_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (we),
        .waddr (IDX_W'(head_reg - SIZE_W'(1))),
        .wdata (IDX_W'(idx_reg)),
        .raddr (IDX_W'(head_reg)),
        .rdata (rdata)
    );

    always_comb
    begin
        if (pool_size == '0)
        begin
            clamped = SIZE_W'(1);
        end
        else if (32'(pool_size) > 32'(POOL_DEPTH))
        begin
            clamped = SIZE_W'(POOL_DEPTH);
        end
        else
        begin
            clamped = pool_size;
        end
    end

    always_comb
    begin
        head_next   = head_reg;
        mark_next   = mark_reg;
        active_next = active_reg;
        slot_next   = NONE_INDEX;
        status_next = STAT_OK;
        mul_a       = '0;
        mul_en      = 1'b0;
        we          = 1'b0;
        case (op_t'(op_reg))
            OP_OBTAIN:
            begin
                if (head_reg < active_reg)
                begin
                    slot_next = (head_reg >= mark_reg) ? INDEX_W'(head_reg)
                                                       : INDEX_W'(rdata);
                    mul_a     = slot_next;
                    mul_en    = 1'b1;
                    head_next = head_reg + SIZE_W'(1);
                    if (head_reg >= mark_reg)
                    begin
                        mark_next = head_reg + SIZE_W'(1);
                    end
                end
                else
                begin
                    status_next = STAT_EXHAUSTED;
                end
            end
            OP_RELEASE:
            begin
                slot_next = idx_reg;
                if (idx_reg == NONE_INDEX || idx_reg >= INDEX_W'(active_reg))
                begin
                    status_next = STAT_INVALID;
                end
                else if (head_reg == '0)
                begin
                    status_next = STAT_UNDERFLOW;
                end
                else
                begin
                    head_next = head_reg - SIZE_W'(1);
                    we        = cmd.commit;
                end
            end
            OP_FREE_ALL:
            begin
                active_next = clamped;
                head_next   = '0;
                mark_next   = '0;
            end
            OP_ACCESS:
            begin
                if (idx_reg == NONE_INDEX)
                begin
                    status_next = STAT_INVALID;
                end
                else
                begin
                    slot_next = idx_reg;
                    mul_a     = idx_reg;
                    mul_en    = 1'b1;
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
        product     = (2*INDEX_W)'(mul_a) * (2*INDEX_W)'(object_size);
        offset_next = mul_en ? product[OFFSET_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            mark_reg      <= '0;
            active_reg    <= ACTIVE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                head_reg      <= head_next;
                mark_reg      <= mark_next;
                active_reg    <= active_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op;
            idx_reg <= index;
        end
        if (cmd.commit)
        begin
            slot_reg   <= slot_next;
            offset_reg <= offset_next;
            status_reg <= status_next;
            used_reg   <= head_next;
        end
    end

    assign flags.out_busy = out_valid_reg && !out_ready;
    assign out_valid      = out_valid_reg;
    assign slot           = slot_reg;
    assign byte_offset    = offset_reg;
    assign status         = status_reg;
    assign used_count     = used_reg;

    a_head_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= active_reg)
        else $error("stack head beyond active pool size");

    a_head_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= mark_reg && mark_reg <= active_reg)
        else $error("fill mark out of order with head or pool size");

    a_commit_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && !out_ready))
        else $error("result committed over an untaken result");
endmodule

@@ hw/rtl/free_index_stack_pool.sv @@
// Flow: a request is captured, then the stack access and offset multiply
// run and the result register loads once it is free; the next request is
// taken only after that commit; the stack RAM's registered read sets the pace.
// Reset: no slot handed out, pool_size 1024, object_size 64, active size
// min(1024, POOL_DEPTH); the stack needs no clearing pass, a fill mark serves.
module free_index_stack_pool
    import fisp_pkg::*;
#(
    parameter int POOL_DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    fisp_req_if.sink          req,
    fisp_rsp_if.source        rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);
    logic [SIZE_W-1:0] pool_size_reg;
    logic [OBJ_W-1:0]  object_size_reg;
    logic              cfg_write;
    reg_sel_t          reg_sel;
    ctrl_cmd_t         cmd;
    dp_flags_t         flags;

    // Registers sit on 4-byte boundaries; decode on the word address bit.
    assign pready    = 1'b1;
    assign reg_sel   = reg_sel_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg   <= POOL_SIZE_RESET;
            object_size_reg <= OBJECT_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_POOL_SIZE:   pool_size_reg   <= pwdata[SIZE_W-1:0];
                REG_OBJECT_SIZE: object_size_reg <= pwdata[OBJ_W-1:0];
                default:         pool_size_reg   <= pool_size_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_POOL_SIZE:   prdata = DATA_W'(pool_size_reg);
            REG_OBJECT_SIZE: prdata = DATA_W'(object_size_reg);
            default:         prdata = '0;
        endcase
    end

    // Controller: accept a request, then commit once the result register
    // can take the new result (hold while a finished result is not taken).
    fisp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .flags     (flags),
        .cmd       (cmd)
    );

    // Datapath: free-index stack, head and fill mark, offset multiplier,
    // result register.
    fisp_dp #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .flags       (flags),
        .op          (req.op),
        .index       (req.index),
        .pool_size   (pool_size_reg),
        .object_size (object_size_reg),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .slot        (rsp.slot),
        .byte_offset (rsp.byte_offset),
        .status      (rsp.status),
        .used_count  (rsp.used_count)
    );
endmodule
